// ===== rtl/lmsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsgd_pkg: shared types, codes and fixed-point helpers
// Word format, command/loss/register codes and saturating arithmetic
// used by the linear-model SGD trainer.
// ----------------------------------------------------------------------------
package lmsgd_pkg;

	localparam int WORD_BITS        = 32;
	localparam int FRAC_BITS        = 16;
	localparam int MAX_FEATURES_DEF = 64;
	localparam int PROD_BITS        = 2 * WORD_BITS;
	localparam int DIV_BITS         = WORD_BITS + FRAC_BITS;
	localparam int CNT_BITS         = 32;
	localparam int CFG_IDX_BITS     = 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;
	localparam word_t HALF_Q   = word_t'(1) <<< (FRAC_BITS - 1);
	localparam prod_t PROD_WMAX = prod_t'(WORD_MAX);
	localparam prod_t PROD_WMIN = prod_t'(WORD_MIN);
	localparam prod_t FRAC_MASK = (prod_t'(1) <<< FRAC_BITS) - prod_t'(1);

	// input commands
	typedef enum logic [1:0] {
		CMD_TRAIN = 2'd0,
		CMD_SCORE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// loss kinds
	localparam logic [1:0] LOSS_SQUARED  = 2'd0;
	localparam logic [1:0] LOSS_LOGISTIC = 2'd1;
	localparam logic [1:0] LOSS_HINGE    = 2'd2;
	localparam logic [1:0] LOSS_EPS      = 2'd3;

	// penalty kinds
	localparam logic REG_L1 = 1'b0;
	localparam logic REG_L2 = 1'b1;

	// result kinds
	localparam logic RES_SCORE  = 1'b0;
	localparam logic RES_WEIGHT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOSS_KIND     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REG_KIND      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEARN_RATE    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REG_STRENGTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EPSILON       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FEATURE_COUNT = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_UPDATES   = 3'd6;

	function automatic word_t sat_add(word_t a, word_t b);
		logic [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

	function automatic word_t sat_neg(word_t v);
		return (v == WORD_MIN) ? WORD_MAX : -v;
	endfunction

	// product scaled down toward zero (when frac set), saturated to a word
	function automatic word_t mul_round(prod_t p, logic frac);
		prod_t t;
		if (!frac)
			t = p;
		else if (p < 0)
			t = (p + FRAC_MASK) >>> FRAC_BITS;
		else
			t = p >>> FRAC_BITS;
		if (t > PROD_WMAX) return WORD_MAX;
		if (t < PROD_WMIN) return WORD_MIN;
		return word_t'(t[WORD_BITS-1:0]);
	endfunction

	// clamp(0.5 + z/4, 0, 1), z/4 toward zero
	function automatic word_t sigmoid(word_t z);
		word_t q;
		word_t s;
		q = (z < 0) ? ((z + word_t'(3)) >>> 2) : (z >>> 2);
		s = sat_add(HALF_Q, q);
		if (s < 0) return '0;
		if (s > ONE_Q) return ONE_Q;
		return s;
	endfunction

	// penalty term; prod is lambda*w from the multiplier
	function automatic word_t penalty(word_t w, word_t lam, logic kind, word_t prod);
		if (kind == REG_L2) return prod;
		if (w > 0) return lam;
		if (w < 0) return sat_neg(lam);
		return '0;
	endfunction

endpackage

// ===== rtl/lmsgd_ram.sv =====
// ----------------------------------------------------------------------------
// lmsgd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lmsgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/linear_model_sgd_trainer.sv =====
// ----------------------------------------------------------------------------
// linear_model_sgd_trainer: online linear-model scorer and SGD trainer
// Buffers feature words, scores each completed sample and, for training
// samples under the update limit, updates the weights of its features and the bias.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (item_valid/item_stall): one word per item. Commands
//    train/score bring one feature; the element that reaches feature_count
//    completes the sample and carries the target. Read returns one weight,
//    clear zeroes the model (no result).
//  - Output channel (result_valid/result_stall): one result word per
//    completed sample or weight read, held in an output register.
//  - A training sample runs the dot product, the penalty sum and the
//    weight update feature by feature, and two passes of the shared
//    restoring divider (penalty mean and decayed rate). All products go
//    through one 32x32 multiplier.
//  - item_stall is high while a sample or read is being worked on.
//  - A stalled result stays in the output register; a new item is taken
//    meanwhile, and a following result waits in its final state.
//  - Reset clears the model, the element count and the registers to their
//    defaults. Weights are zeroed through per-entry valid bits, so reset
//    and clear take effect at once.
// ----------------------------------------------------------------------------
module linear_model_sgd_trainer #(
	parameter int MAX_FEATURES = lmsgd_pkg::MAX_FEATURES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration
	input  logic                                    cfg_we,
	input  logic [lmsgd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [31:0]                             cfg_data,
	// input channel
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  logic [1:0]                              command,
	input  logic signed [lmsgd_pkg::WORD_BITS-1:0]  feature_value,
	input  logic signed [lmsgd_pkg::WORD_BITS-1:0]  target_label,
	input  logic [5:0]                              weight_index,
	// output channel
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic                                    result_kind,
	output logic signed [lmsgd_pkg::WORD_BITS-1:0]  raw_score,
	output logic signed [lmsgd_pkg::WORD_BITS-1:0]  decision,
	output logic signed [lmsgd_pkg::WORD_BITS-1:0]  bias_value,
	output logic signed [lmsgd_pkg::WORD_BITS-1:0]  weight_value
);

	localparam int W   = lmsgd_pkg::WORD_BITS;
	localparam int AW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW  = $clog2(MAX_FEATURES + 1);
	localparam int DB  = lmsgd_pkg::DIV_BITS;
	localparam int DCW = $clog2(DB + 1);

	typedef enum logic [25:0] {
		ST_IDLE     = 26'd1 << 0,
		ST_RBK      = 26'd1 << 1,
		ST_DOT_RD   = 26'd1 << 2,
		ST_DOT_MUL  = 26'd1 << 3,
		ST_DOT_ACC  = 26'd1 << 4,
		ST_DEC      = 26'd1 << 5,
		ST_G_MUL1   = 26'd1 << 6,
		ST_G_MUL2   = 26'd1 << 7,
		ST_G_FIN    = 26'd1 << 8,
		ST_R_RD     = 26'd1 << 9,
		ST_R_MUL    = 26'd1 << 10,
		ST_R_ACC    = 26'd1 << 11,
		ST_RB_MUL   = 26'd1 << 12,
		ST_R_DSET   = 26'd1 << 13,
		ST_R_DIV    = 26'd1 << 14,
		ST_ETA_MUL1 = 26'd1 << 15,
		ST_ETA_MUL2 = 26'd1 << 16,
		ST_ETA_DSET = 26'd1 << 17,
		ST_ETA_DIV  = 26'd1 << 18,
		ST_U_RD     = 26'd1 << 19,
		ST_U_MUL1   = 26'd1 << 20,
		ST_U_MUL2   = 26'd1 << 21,
		ST_U_WR     = 26'd1 << 22,
		ST_B_MUL    = 26'd1 << 23,
		ST_B_FIN    = 26'd1 << 24,
		ST_OUT      = 26'd1 << 25
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0]  loss_kind_q;
	logic        reg_kind_q;
	logic [30:0] learn_rate_q;
	logic [30:0] reg_strength_q;
	logic [30:0] epsilon_q;
	logic [6:0]  feature_count_q;
	logic [lmsgd_pkg::CNT_BITS-1:0] max_updates_q;

	// model state
	logic [MAX_FEATURES-1:0]        wvalid_q;
	lmsgd_pkg::word_t               bias_q;
	logic [lmsgd_pkg::CNT_BITS-1:0] ucount_q;
	logic [CW-1:0]                  ecount_q;

	// sample work registers
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    idx_q;
	logic             train_q;
	lmsgd_pkg::word_t y_q;
	lmsgd_pkg::word_t acc_q;
	lmsgd_pkg::word_t dec_q;
	lmsgd_pkg::word_t g_q;
	lmsgd_pkg::word_t rsum_q;
	lmsgd_pkg::word_t rb_q;
	lmsgd_pkg::word_t rmean_q;
	logic             rneg_q;
	lmsgd_pkg::word_t prod_q;
	logic             wvld_q;
	logic             rbk_ok_q;
	lmsgd_pkg::word_t rbk_word_q;
	logic             res_kind_q;

	// divider
	logic [DB-1:0]  div_num_q;
	logic [W:0]     div_rem_q;
	logic [W-1:0]   div_den_q;
	logic [DCW-1:0] div_cnt_q;
	logic [W:0]     div_rem_sh;
	logic           div_ge;

	// output register
	logic             res_valid_q;
	logic             res_kind_o_q;
	lmsgd_pkg::word_t raw_o_q;
	lmsgd_pkg::word_t dec_o_q;
	lmsgd_pkg::word_t bias_o_q;
	lmsgd_pkg::word_t wt_o_q;

	// memories and read data
	logic [AW-1:0]    w_raddr;
	logic [W-1:0]     w_dout;
	logic [W-1:0]     s_dout;
	logic             w_we;
	lmsgd_pkg::word_t w_wdata;
	lmsgd_pkg::word_t w_rd;
	lmsgd_pkg::word_t x_rd;

	// shared multiplier
	lmsgd_pkg::word_t mul_a;
	lmsgd_pkg::word_t mul_b;
	logic             mul_frac;
	lmsgd_pkg::prod_t mul_p;

	logic             accept;
	logic             elem_in;
	logic             last_idx;
	logic [CW-1:0]    n_eff;
	logic [CW:0]      ecount_nx;
	lmsgd_pkg::word_t lam;
	lmsgd_pkg::word_t eta;
	lmsgd_pkg::word_t eps;
	lmsgd_pkg::word_t ucount_sat;
	lmsgd_pkg::word_t eta_t;
	lmsgd_pkg::word_t diff_ay;
	lmsgd_pkg::word_t diff_ya;
	logic [W-1:0]     rsum_abs;
	logic             out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign elem_in    = accept && (command == lmsgd_pkg::CMD_TRAIN ||
		command == lmsgd_pkg::CMD_SCORE);
	assign out_free   = !res_valid_q || !result_stall;

	assign lam = lmsgd_pkg::word_t'({1'b0, reg_strength_q});
	assign eta = lmsgd_pkg::word_t'({1'b0, learn_rate_q});
	assign eps = lmsgd_pkg::word_t'({1'b0, epsilon_q});
	assign ucount_sat = (ucount_q > lmsgd_pkg::CNT_BITS'(lmsgd_pkg::WORD_MAX)) ?
		lmsgd_pkg::WORD_MAX : lmsgd_pkg::word_t'(ucount_q);

	// feature count clamped to 1..MAX_FEATURES
	always_comb begin
		if (feature_count_q == '0)
			n_eff = CW'(1);
		else if (32'(feature_count_q) > 32'(MAX_FEATURES))
			n_eff = CW'(MAX_FEATURES);
		else
			n_eff = CW'(feature_count_q);
	end
	assign ecount_nx = {1'b0, ecount_q} + (CW+1)'(1);
	assign last_idx  = (idx_q == n_q - CW'(1));

	// weight store: invalid entries read as zero
	assign w_raddr = (state_q == ST_IDLE) ? AW'(weight_index) : idx_q[AW-1:0];
	assign w_rd    = wvld_q ? lmsgd_pkg::word_t'(w_dout) : '0;
	assign x_rd    = lmsgd_pkg::word_t'(s_dout);
	assign w_we    = (state_q == ST_U_WR);
	assign w_wdata = lmsgd_pkg::sat_add(w_rd, lmsgd_pkg::sat_neg(prod_q));

	lmsgd_ram #(.WIDTH(W), .DEPTH(MAX_FEATURES)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_dout)
	);

	lmsgd_ram #(.WIDTH(W), .DEPTH(MAX_FEATURES)) u_sample_ram (
		.clk   (clk),
		.we    (elem_in),
		.waddr (ecount_q[AW-1:0]),
		.wdata (feature_value),
		.raddr (idx_q[AW-1:0]),
		.rdata (s_dout)
	);

	// rate = floor(eta*2^F / den); quotient saturates to the word
	assign eta_t = (|div_num_q[DB-1:W-1]) ? lmsgd_pkg::WORD_MAX :
		lmsgd_pkg::word_t'(div_num_q[W-1:0]);
	assign rsum_abs = rsum_q[W-1] ? W'(-rsum_q) : W'(rsum_q);

	// restoring divider, one quotient bit per cycle
	assign div_rem_sh = {div_rem_q[W-1:0], div_num_q[DB-1]};
	assign div_ge     = (div_rem_sh >= {1'b0, div_den_q});

	assign diff_ay = lmsgd_pkg::sat_add(acc_q, lmsgd_pkg::sat_neg(y_q));
	assign diff_ya = lmsgd_pkg::sat_add(y_q, lmsgd_pkg::sat_neg(acc_q));

	// operand select for the one multiplier
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_frac = 1'b1;
		case (state_q)
			ST_DOT_MUL: begin
				mul_a = w_rd;
				mul_b = x_rd;
			end
			ST_G_MUL1: begin
				mul_a = y_q;
				mul_b = acc_q;
			end
			ST_G_MUL2: begin
				mul_a = y_q;
				mul_b = lmsgd_pkg::sigmoid(lmsgd_pkg::sat_neg(prod_q));
			end
			ST_R_MUL: begin
				mul_a = lam;
				mul_b = w_rd;
			end
			ST_RB_MUL: begin
				mul_a = lam;
				mul_b = bias_q;
			end
			ST_ETA_MUL1: begin
				mul_a = lam;
				mul_b = eta;
			end
			ST_ETA_MUL2: begin
				mul_a    = prod_q;
				mul_b    = ucount_sat;
				mul_frac = 1'b0;
			end
			ST_U_MUL1: begin
				mul_a = g_q;
				mul_b = x_rd;
			end
			ST_U_MUL2: begin
				mul_a = eta_t;
				mul_b = lmsgd_pkg::sat_add(prod_q, rmean_q);
			end
			ST_B_MUL: begin
				mul_a = eta_t;
				mul_b = lmsgd_pkg::sat_add(g_q, rb_q);
			end
			default: begin
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= lmsgd_pkg::mul_round(mul_p, mul_frac);
		wvld_q <= wvalid_q[w_raddr];
		if (accept && command == lmsgd_pkg::CMD_READ)
			rbk_ok_q <= (32'(weight_index) < 32'(MAX_FEATURES));
		if (elem_in && ecount_nx >= {1'b0, n_eff}) begin
			y_q     <= target_label;
			n_q     <= n_eff;
			train_q <= (command == lmsgd_pkg::CMD_TRAIN) && (ucount_q < max_updates_q);
		end
		case (state_q)
			ST_RBK: begin
				rbk_word_q <= (rbk_ok_q && wvld_q) ? lmsgd_pkg::word_t'(w_dout) : '0;
				res_kind_q <= lmsgd_pkg::RES_WEIGHT;
			end
			ST_DEC: begin
				res_kind_q <= lmsgd_pkg::RES_SCORE;
				rbk_word_q <= '0;
				rsum_q     <= '0;
				case (loss_kind_q)
					lmsgd_pkg::LOSS_LOGISTIC:
						dec_q <= (lmsgd_pkg::sigmoid(acc_q) > lmsgd_pkg::HALF_Q) ?
							lmsgd_pkg::ONE_Q : lmsgd_pkg::sat_neg(lmsgd_pkg::ONE_Q);
					lmsgd_pkg::LOSS_HINGE:
						dec_q <= (acc_q > 0) ?
							lmsgd_pkg::ONE_Q : lmsgd_pkg::sat_neg(lmsgd_pkg::ONE_Q);
					default:
						dec_q <= acc_q;
				endcase
				case (loss_kind_q)
					lmsgd_pkg::LOSS_SQUARED: g_q <= diff_ay;
					lmsgd_pkg::LOSS_EPS: begin
						if (diff_ay > eps)
							g_q <= lmsgd_pkg::ONE_Q;
						else if (diff_ya > eps)
							g_q <= lmsgd_pkg::sat_neg(lmsgd_pkg::ONE_Q);
						else
							g_q <= '0;
					end
					default: g_q <= '0;
				endcase
			end
			ST_G_MUL2: begin
				if (loss_kind_q == lmsgd_pkg::LOSS_HINGE)
					g_q <= (prod_q < lmsgd_pkg::ONE_Q) ? lmsgd_pkg::sat_neg(y_q) : '0;
			end
			ST_G_FIN: g_q <= lmsgd_pkg::sat_neg(prod_q);
			ST_R_ACC:
				rsum_q <= lmsgd_pkg::sat_add(rsum_q,
					lmsgd_pkg::penalty(w_rd, lam, reg_kind_q, prod_q));
			ST_R_DSET: begin
				rb_q      <= lmsgd_pkg::penalty(bias_q, lam, reg_kind_q, prod_q);
				rneg_q    <= rsum_q[W-1];
				div_num_q <= DB'(rsum_abs);
				div_den_q <= W'(n_q);
				div_rem_q <= '0;
			end
			ST_ETA_MUL1:
				rmean_q <= rneg_q ? lmsgd_pkg::word_t'(-div_num_q[W-1:0]) :
					lmsgd_pkg::word_t'(div_num_q[W-1:0]);
			ST_ETA_DSET: begin
				div_num_q <= {eta[W-1:0], {lmsgd_pkg::FRAC_BITS{1'b0}}};
				div_den_q <= W'(lmsgd_pkg::sat_add(lmsgd_pkg::ONE_Q, prod_q));
				div_rem_q <= '0;
			end
			ST_R_DIV, ST_ETA_DIV: begin
				div_rem_q <= div_ge ? (div_rem_sh - {1'b0, div_den_q}) : div_rem_sh;
				div_num_q <= {div_num_q[DB-2:0], div_ge};
			end
			default: begin
			end
		endcase
		if (state_q == ST_IDLE)
			acc_q <= bias_q;
		else if (state_q == ST_DOT_ACC)
			acc_q <= lmsgd_pkg::sat_add(acc_q, prod_q);
		if (state_q == ST_OUT && out_free) begin
			res_kind_o_q <= res_kind_q;
			raw_o_q      <= (res_kind_q == lmsgd_pkg::RES_WEIGHT) ? '0 : acc_q;
			dec_o_q      <= (res_kind_q == lmsgd_pkg::RES_WEIGHT) ? '0 : dec_q;
			bias_o_q     <= bias_q;
			wt_o_q       <= rbk_word_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			loss_kind_q     <= lmsgd_pkg::LOSS_SQUARED;
			reg_kind_q      <= lmsgd_pkg::REG_L1;
			learn_rate_q    <= 31'd655;
			reg_strength_q  <= 31'd66;
			epsilon_q       <= 31'd66;
			feature_count_q <= 7'd64;
			max_updates_q   <= 32'd1000;
			wvalid_q        <= '0;
			bias_q          <= '0;
			ucount_q        <= '0;
			ecount_q        <= '0;
			idx_q           <= '0;
			div_cnt_q       <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lmsgd_pkg::CFG_LOSS_KIND:     loss_kind_q     <= cfg_data[1:0];
					lmsgd_pkg::CFG_REG_KIND:      reg_kind_q      <= cfg_data[0];
					lmsgd_pkg::CFG_LEARN_RATE:    learn_rate_q    <= cfg_data[30:0];
					lmsgd_pkg::CFG_REG_STRENGTH:  reg_strength_q  <= cfg_data[30:0];
					lmsgd_pkg::CFG_EPSILON:       epsilon_q       <= cfg_data[30:0];
					lmsgd_pkg::CFG_FEATURE_COUNT: feature_count_q <= cfg_data[6:0];
					lmsgd_pkg::CFG_MAX_UPDATES:   max_updates_q   <= cfg_data[31:0];
					default: begin
					end
				endcase
			end

			// output word: loaded from the final state, dropped once taken
			if (state_q == ST_OUT && out_free)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							lmsgd_pkg::CMD_CLEAR: begin
								wvalid_q <= '0;
								bias_q   <= '0;
								ucount_q <= '0;
								ecount_q <= '0;
							end
							lmsgd_pkg::CMD_READ: state_q <= ST_RBK;
							default: begin
								if (ecount_nx >= {1'b0, n_eff}) begin
									ecount_q <= '0;
									idx_q    <= '0;
									state_q  <= ST_DOT_RD;
								end else begin
									ecount_q <= ecount_nx[CW-1:0];
								end
							end
						endcase
					end
				end
				ST_RBK:     state_q <= ST_OUT;
				ST_DOT_RD:  state_q <= ST_DOT_MUL;
				ST_DOT_MUL: state_q <= ST_DOT_ACC;
				ST_DOT_ACC: begin
					if (last_idx) begin
						state_q <= ST_DEC;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_DOT_RD;
					end
				end
				ST_DEC: begin
					idx_q <= '0;
					if (!train_q)
						state_q <= ST_OUT;
					else if (loss_kind_q == lmsgd_pkg::LOSS_LOGISTIC ||
						loss_kind_q == lmsgd_pkg::LOSS_HINGE)
						state_q <= ST_G_MUL1;
					else
						state_q <= ST_R_RD;
				end
				ST_G_MUL1: state_q <= ST_G_MUL2;
				ST_G_MUL2: state_q <= (loss_kind_q == lmsgd_pkg::LOSS_HINGE) ?
					ST_R_RD : ST_G_FIN;
				ST_G_FIN:  state_q <= ST_R_RD;
				ST_R_RD:   state_q <= ST_R_MUL;
				ST_R_MUL:  state_q <= ST_R_ACC;
				ST_R_ACC: begin
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= ST_RB_MUL;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_R_RD;
					end
				end
				ST_RB_MUL: state_q <= ST_R_DSET;
				ST_R_DSET: begin
					div_cnt_q <= DCW'(DB);
					state_q   <= ST_R_DIV;
				end
				ST_R_DIV: begin
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == DCW'(1))
						state_q <= ST_ETA_MUL1;
				end
				ST_ETA_MUL1: state_q <= ST_ETA_MUL2;
				ST_ETA_MUL2: state_q <= ST_ETA_DSET;
				ST_ETA_DSET: begin
					div_cnt_q <= DCW'(DB);
					state_q   <= ST_ETA_DIV;
				end
				ST_ETA_DIV: begin
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == DCW'(1))
						state_q <= ST_U_RD;
				end
				ST_U_RD:   state_q <= ST_U_MUL1;
				ST_U_MUL1: state_q <= ST_U_MUL2;
				ST_U_MUL2: state_q <= ST_U_WR;
				ST_U_WR: begin
					wvalid_q[idx_q[AW-1:0]] <= 1'b1;
					if (last_idx) begin
						state_q <= ST_B_MUL;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_U_RD;
					end
				end
				ST_B_MUL: state_q <= ST_B_FIN;
				ST_B_FIN: begin
					bias_q   <= lmsgd_pkg::sat_add(bias_q, lmsgd_pkg::sat_neg(prod_q));
					ucount_q <= ucount_q + lmsgd_pkg::CNT_BITS'(1);
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_o_q;
	assign raw_score    = raw_o_q;
	assign decision     = dec_o_q;
	assign bias_value   = bias_o_q;
	assign weight_value = wt_o_q;

	// a clear zeroes the model on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == lmsgd_pkg::CMD_CLEAR |=> bias_q == '0 && ucount_q == '0
		&& wvalid_q == '0)
		else $error("clear did not zero the model");

	// the update count only steps by one or returns to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		ucount_q != $past(ucount_q) |->
		ucount_q == $past(ucount_q) + lmsgd_pkg::CNT_BITS'(1) || ucount_q == '0)
		else $error("update count jumped");

	// the divider counts only inside its two passes
	assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q != '0 |-> state_q == ST_R_DIV || state_q == ST_ETA_DIV)
		else $error("divider active outside a divide pass");

	// a new result word only comes out of the final state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output state");

	// the bias moves only on a clear or at the end of an update
	assert property (@(posedge clk) disable iff (!arst_n)
		bias_q != $past(bias_q) |-> $past(state_q) == ST_B_FIN || bias_q == '0)
		else $error("bias changed outside an update");

endmodule
